// ===== src/cps_pkg.sv =====
// Shared constants, types and helpers for the closest-point-on-segment unit.
`timescale 1ns / 1ps

package cps_pkg;

  // Coordinate width and the widths that follow from it.
  localparam int COORD_BITS = 16;
  localparam int DW         = COORD_BITS + 1;          // coordinate differences
  localparam int PW         = 2 * DW;                  // signed difference products
  localparam int TW         = PW + 1;                  // projection sum
  localparam int LW         = 2 * COORD_BITS + 1;      // squared length, projection in range
  localparam int NW         = COORD_BITS + LW;         // dividend of the scaling
  localparam int SQW        = 2 * COORD_BITS;          // one squared component
  localparam int DSW        = 2 * COORD_BITS + 1;      // squared distance
  localparam int RW         = 2;                       // region code

  // Stream widths, padded to whole bytes.
  localparam int IN_RAW  = 6 * COORD_BITS;
  localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
  localparam int OUT_RAW = 2 * COORD_BITS + RW + DSW;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  // Register stages from the input edge to the output register, inclusive.
  localparam int PIPE_DEPTH = COORD_BITS + 10;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         diff_t;

  typedef enum logic [RW-1:0] {
    REG_BEFORE = 2'd0,
    REG_BEYOND = 2'd1,
    REG_INSIDE = 2'd2
  } region_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } query_t;

  // Per-request information that rides alongside the divider.
  typedef struct packed {
    query_t  q;
    region_t region;
    logic    neg_x;
    logic    neg_y;
    logic    zero_len;
  } side_t;

  // Sign-extend a coordinate by one bit.
  function automatic diff_t ext(input coord_t v);
    ext = $signed({v[COORD_BITS-1], v});
  endfunction

endpackage

// ===== src/cps_front.sv =====
// Front end: differences, dot products, region decision and scaled dividends.
`timescale 1ns / 1ps

module cps_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  cps_pkg::query_t         in_query,
  output logic                    out_valid,
  output logic [cps_pkg::NW-1:0]  num_x,
  output logic [cps_pkg::NW-1:0]  num_y,
  output logic [cps_pkg::LW-1:0]  len,
  output cps_pkg::side_t          side
);
  import cps_pkg::*;

  // Stage 1 registers.
  logic   v1;
  query_t q1;
  diff_t  dx1, dy1, spx1, spy1;

  // Stage 2 registers.
  logic                 v2;
  query_t               q2;
  diff_t                dx2, dy2;
  logic signed [PW-1:0] pa2, pb2, pc2, pd2;

  // Stage 3 registers.
  logic                  v3;
  query_t                q3;
  logic signed [TW-1:0]  t3;
  logic [LW-1:0]         len3;
  logic [COORD_BITS-1:0] mx3, my3;
  logic                  nx3, ny3;

  // Stage 4 registers.
  logic                  v4;
  query_t                q4;
  region_t               reg4;
  logic [LW-1:0]         tm4, len4;
  logic [COORD_BITS-1:0] mx4, my4;
  logic                  nx4, ny4, z4;

  // Combinational magnitudes of the stage 2 differences.
  diff_t adx2, ady2;
  region_t reg_c;

  assign adx2 = dx2[DW-1] ? -dx2 : dx2;
  assign ady2 = dy2[DW-1] ? -dy2 : dy2;

  // Region from the sign of the projection and its compare with the length.
  always_comb begin
    if (t3[TW-1]) begin
      reg_c = REG_BEFORE;
    end else if (t3[TW-2:0] > (TW-1)'(len3)) begin
      reg_c = REG_BEYOND;
    end else begin
      reg_c = REG_INSIDE;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (en) begin
      // Segment direction and point offset.
      q1   <= in_query;
      dx1  <= ext(in_query.ex) - ext(in_query.sx);
      dy1  <= ext(in_query.ey) - ext(in_query.sy);
      spx1 <= ext(in_query.px) - ext(in_query.sx);
      spy1 <= ext(in_query.py) - ext(in_query.sy);

      // Four signed products.
      q2  <= q1;
      dx2 <= dx1;
      dy2 <= dy1;
      pa2 <= PW'(dx1) * PW'(spx1);
      pb2 <= PW'(dy1) * PW'(spy1);
      pc2 <= PW'(dx1) * PW'(dx1);
      pd2 <= PW'(dy1) * PW'(dy1);

      // Projection and squared length.
      q3   <= q2;
      t3   <= $signed({pa2[PW-1], pa2}) + $signed({pb2[PW-1], pb2});
      len3 <= pc2[LW-1:0] + pd2[LW-1:0];
      mx3  <= adx2[COORD_BITS-1:0];
      my3  <= ady2[COORD_BITS-1:0];
      nx3  <= dx2[DW-1];
      ny3  <= dy2[DW-1];

      // Region and degenerate-segment flag.
      q4   <= q3;
      reg4 <= reg_c;
      tm4  <= t3[LW-1:0];
      len4 <= len3;
      mx4  <= mx3;
      my4  <= my3;
      nx4  <= nx3;
      ny4  <= ny3;
      z4   <= (len3 == '0);

      // Dividends for the per-axis scaling.
      num_x         <= NW'(mx4) * NW'(tm4);
      num_y         <= NW'(my4) * NW'(tm4);
      len           <= len4;
      side.q        <= q4;
      side.region   <= reg4;
      side.neg_x    <= nx4;
      side.neg_y    <= ny4;
      side.zero_len <= z4;
    end
  end

endmodule

// ===== src/cps_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, both axes side by side.
`timescale 1ns / 1ps

module cps_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [cps_pkg::NW-1:0]         num_x,
  input  logic [cps_pkg::NW-1:0]         num_y,
  input  logic [cps_pkg::LW-1:0]         len,
  input  cps_pkg::side_t                 in_side,
  output logic                           out_valid,
  output logic [cps_pkg::COORD_BITS-1:0] q_x,
  output logic [cps_pkg::COORD_BITS-1:0] q_y,
  output cps_pkg::side_t                 out_side
);
  import cps_pkg::*;

  // One register set per stage; entry zero holds the loaded dividend.
  logic                  v  [0:COORD_BITS];
  logic [LW-1:0]         rx [0:COORD_BITS];
  logic [LW-1:0]         ry [0:COORD_BITS];
  logic [COORD_BITS-1:0] lx [0:COORD_BITS];
  logic [COORD_BITS-1:0] ly [0:COORD_BITS];
  logic [COORD_BITS-1:0] qx [0:COORD_BITS];
  logic [COORD_BITS-1:0] qy [0:COORD_BITS];
  logic [LW-1:0]         dl [0:COORD_BITS];
  side_t                 sd [0:COORD_BITS];

  // Load stage: the upper dividend bits start as the partial remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx[0] <= num_x[NW-1:COORD_BITS];
      ry[0] <= num_y[NW-1:COORD_BITS];
      lx[0] <= num_x[COORD_BITS-1:0];
      ly[0] <= num_y[COORD_BITS-1:0];
      qx[0] <= '0;
      qy[0] <= '0;
      dl[0] <= len;
      sd[0] <= in_side;
    end
  end

  // Each stage shifts in one dividend bit and subtracts the divisor if it fits.
  for (genvar k = 1; k <= COORD_BITS; k++) begin : g_step
    logic [LW:0] tx, ty, dxx, dyy;
    logic        bx, by;

    assign tx  = {rx[k-1], lx[k-1][COORD_BITS-1]};
    assign ty  = {ry[k-1], ly[k-1][COORD_BITS-1]};
    assign bx  = (tx >= {1'b0, dl[k-1]});
    assign by  = (ty >= {1'b0, dl[k-1]});
    assign dxx = tx - {1'b0, dl[k-1]};
    assign dyy = ty - {1'b0, dl[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx[k] <= bx ? dxx[LW-1:0] : tx[LW-1:0];
        ry[k] <= by ? dyy[LW-1:0] : ty[LW-1:0];
        lx[k] <= {lx[k-1][COORD_BITS-2:0], 1'b0};
        ly[k] <= {ly[k-1][COORD_BITS-2:0], 1'b0};
        qx[k] <= {qx[k-1][COORD_BITS-2:0], bx};
        qy[k] <= {qy[k-1][COORD_BITS-2:0], by};
        dl[k] <= dl[k-1];
        sd[k] <= sd[k-1];
      end
    end
  end

  assign out_valid = v[COORD_BITS];
  assign q_x       = qx[COORD_BITS];
  assign q_y       = qy[COORD_BITS];
  assign out_side  = sd[COORD_BITS];

endmodule

// ===== src/cps_back.sv =====
// Back end: closest point selection and squared distance.
`timescale 1ns / 1ps

module cps_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [cps_pkg::COORD_BITS-1:0] q_x,
  input  logic [cps_pkg::COORD_BITS-1:0] q_y,
  input  cps_pkg::side_t                 in_side,
  output logic                           out_valid,
  output cps_pkg::coord_t                near_x,
  output cps_pkg::coord_t                near_y,
  output cps_pkg::region_t               region,
  output logic [cps_pkg::DSW-1:0]        dist_squared
);
  import cps_pkg::*;

  // Stage 1 registers.
  logic    v1;
  coord_t  px1, py1, nx1, ny1;
  region_t reg1;

  // Stage 2 registers.
  logic    v2;
  coord_t  nx2, ny2;
  region_t reg2;
  diff_t   ex2, ey2;

  // Stage 3 registers.
  logic           v3;
  coord_t         nx3, ny3;
  region_t        reg3;
  logic [SQW-1:0] sqx3, sqy3;

  diff_t                offx, offy, sumx, sumy;
  coord_t               selx, sely;
  logic signed [PW-1:0] prx, pry;

  // Signed offset from start along each axis.
  assign offx = in_side.neg_x ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
  assign offy = in_side.neg_y ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
  assign sumx = ext(in_side.q.sx) + offx;
  assign sumy = ext(in_side.q.sy) + offy;

  // Pick start, end or the interpolated point.
  always_comb begin
    case (in_side.region)
      REG_BEFORE: begin
        selx = in_side.q.sx;
        sely = in_side.q.sy;
      end
      REG_BEYOND: begin
        selx = in_side.q.ex;
        sely = in_side.q.ey;
      end
      default: begin
        if (in_side.zero_len) begin
          selx = in_side.q.sx;
          sely = in_side.q.sy;
        end else begin
          selx = sumx[COORD_BITS-1:0];
          sely = sumy[COORD_BITS-1:0];
        end
      end
    endcase
  end

  assign prx = PW'(ex2) * PW'(ex2);
  assign pry = PW'(ey2) * PW'(ey2);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (en) begin
      px1  <= in_side.q.px;
      py1  <= in_side.q.py;
      nx1  <= selx;
      ny1  <= sely;
      reg1 <= in_side.region;

      nx2  <= nx1;
      ny2  <= ny1;
      reg2 <= reg1;
      ex2  <= ext(px1) - ext(nx1);
      ey2  <= ext(py1) - ext(ny1);

      nx3  <= nx2;
      ny3  <= ny2;
      reg3 <= reg2;
      sqx3 <= prx[SQW-1:0];
      sqy3 <= pry[SQW-1:0];
    end
  end

  assign out_valid    = v3;
  assign near_x       = nx3;
  assign near_y       = ny3;
  assign region       = reg3;
  assign dist_squared = DSW'(sqx3) + DSW'(sqy3);

endmodule

// ===== src/closest_point_on_segment_unit.sv =====
// A request passes through five front stages, COORD_BITS + 1 divider stages, three
// back stages and the output register. Throughput: one request per clock unless the
// pipeline is stalled; the divider retires one quotient bit per stage. Backpressure
// stalls the pipeline only when the output register and the last stage both hold
// results. Reset clears all valid bits; no request or result is in flight afterward.
`timescale 1ns / 1ps

module closest_point_on_segment_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // point_x, point_y, start_x, start_y, end_x, end_y
  input  logic [cps_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // near_x, near_y, region, dist_squared, zero fill
  output logic [cps_pkg::OUT_W-1:0] m_axis_tdata
);
  import cps_pkg::*;

  logic                  adv;
  query_t                query;
  logic                  f_valid, d_valid, b_valid;
  logic [NW-1:0]         num_x, num_y;
  logic [LW-1:0]         len;
  side_t                 f_side, d_side;
  logic [COORD_BITS-1:0] q_x, q_y;
  coord_t                near_x, near_y;
  region_t               region;
  logic [DSW-1:0]        dist_squared;
  logic [OUT_RAW-1:0]    out_data;

  // Unpack the request.
  assign query.px = s_axis_tdata[1*COORD_BITS-1:0*COORD_BITS];
  assign query.py = s_axis_tdata[2*COORD_BITS-1:1*COORD_BITS];
  assign query.sx = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign query.sy = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
  assign query.ex = s_axis_tdata[5*COORD_BITS-1:4*COORD_BITS];
  assign query.ey = s_axis_tdata[6*COORD_BITS-1:5*COORD_BITS];

  // The pipeline moves unless a finished result would overwrite a waiting one.
  assign adv           = !(b_valid && m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = adv;

  cps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s_axis_tvalid),
    .in_query  (query),
    .out_valid (f_valid),
    .num_x     (num_x),
    .num_y     (num_y),
    .len       (len),
    .side      (f_side)
  );

  cps_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (f_valid),
    .num_x     (num_x),
    .num_y     (num_y),
    .len       (len),
    .in_side   (f_side),
    .out_valid (d_valid),
    .q_x       (q_x),
    .q_y       (q_y),
    .out_side  (d_side)
  );

  cps_back u_back (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .in_valid     (d_valid),
    .q_x          (q_x),
    .q_y          (q_y),
    .in_side      (d_side),
    .out_valid    (b_valid),
    .near_x       (near_x),
    .near_y       (near_y),
    .region       (region),
    .dist_squared (dist_squared)
  );

  // Output register with its handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv && b_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_valid) begin
      out_data <= {dist_squared, region, near_y, near_x};
    end
  end

  assign m_axis_tdata = {(OUT_W-OUT_RAW)'(0), out_data};

endmodule

// ===== src/cps_checker.sv =====
// Port-level checker for the closest-point unit, bound to the top level.
`timescale 1ns / 1ps

module cps_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [cps_pkg::OUT_W-1:0] m_axis_tdata
);
  import cps_pkg::*;

  logic [7:0] inflight;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Requests accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + {7'd0, in_acc} - {7'd0, out_acc};
    end
  end

  // A waiting result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // A waiting result keeps its data.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // No result without an outstanding request.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> inflight != 8'd0)
    else $error("result without a pending request");

  // The pipeline never holds more than its stage count.
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    inflight <= 8'(PIPE_DEPTH))
    else $error("more requests in flight than pipeline stages");

  // Input stalls only under output backpressure.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

bind closest_point_on_segment_unit cps_checker u_cps_checker (.*);
